// ----- rtl/lskv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lskv_pkg
// Shared codes and types for the linear-search key/value table.
// ----------------------------------------------------------------------------
package lskv_pkg;

  localparam logic [2:0] CMD_READ_INSERT = 3'd0;
  localparam logic [2:0] CMD_WRITE       = 3'd1;
  localparam logic [2:0] CMD_PEEK        = 3'd2;
  localparam logic [2:0] CMD_REMOVE      = 3'd3;
  localparam logic [2:0] CMD_CLEAR       = 3'd4;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic cmp_en;     // capture the key compare result
    logic write_hit;  // matching cell takes the new value
    logic append;     // cell at the current count takes the new pair
    logic remove;     // cells at or above the hit take their neighbor's pair
  } cell_ctrl_t;

endpackage

// ----- rtl/lskv_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lskv_cell
// One entry of the table: holds a key/value pair, compares it against the
// request key and takes its upper neighbor's pair when the list closes a gap.
// ----------------------------------------------------------------------------
module lskv_cell #(
  parameter int INDEX      = 0,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lskv_pkg::cell_ctrl_t   ctrl_i,
  input  logic [KEY_BITS-1:0]    req_key_i,
  input  logic [VALUE_BITS-1:0]  upd_value_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [IDX_W-1:0]       hit_idx_i,
  input  logic [KEY_BITS-1:0]    nbr_key_i,
  input  logic [VALUE_BITS-1:0]  nbr_value_i,
  output logic [KEY_BITS-1:0]    key_o,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   match_o
);
  import lskv_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  match_q;
  logic                  occupied;

  assign occupied = MY_POS < count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= occupied && (key_q == req_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.remove && (MY_IDX >= hit_idx_i)) begin
      key_q   <= nbr_key_i;
      value_q <= nbr_value_i;
    end else if (ctrl_i.append && (MY_POS == count_i)) begin
      key_q   <= req_key_i;
      value_q <= upd_value_i;
    end else if (ctrl_i.write_hit && match_q) begin
      value_q <= upd_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ----- rtl/linear_search_key_value_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_search_key_value_table
// Small associative table kept as a compact list in a row of entry cells.
// ----------------------------------------------------------------------------
// Each request passes a compare state and then an update state. In the
// compare state every occupied cell compares its key with the request key
// and registers the result; in the update state the hit is resolved, the
// row is updated (append at the end, value write, or a one-place shift of
// the entries above a removed one) and the result is loaded into the output
// register. A new request is taken in the same cycle as the update; a held
// result stalls the update cycle. Keys are unique in the list, so at most
// one cell matches. A full table refuses an insert with status full. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module linear_search_key_value_table #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            command_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] write_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           read_value_o,
  output logic [1:0]            status_o,
  output logic [4:0]            entry_count_o
);
  import lskv_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  state_e                state_q, state_d;
  logic [2:0]            cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wv_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [31:0]           read_value_q;
  logic [1:0]            status_q;
  logic [4:0]            entry_count_q;

  logic                  in_xfer;
  logic                  proceed;
  cell_ctrl_t            ctrl;

  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0]    cell_match;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_BITS-1:0] rv;
  logic [1:0]            st;
  logic                  do_write_hit, do_append, do_remove;

  logic [VALUE_BITS+31:0] rv_ext;
  logic [CNT_W+4:0]       count_ext;

  // The update cycle can only finish when the output register is free.
  assign proceed    = (state_q == S_UPD) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || proceed);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   if (proceed) state_d = in_xfer ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Matches are one-hot, so a plain OR gathers index and value.
  always_comb begin
    hit       = |cell_match;
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  always_comb begin
    rv           = '0;
    st           = ST_MISS;
    count_d      = count_q;
    do_write_hit = 1'b0;
    do_append    = 1'b0;
    do_remove    = 1'b0;
    case (cmd_q)
      CMD_READ_INSERT, CMD_WRITE: begin
        if (hit) begin
          do_write_hit = (cmd_q == CMD_WRITE);
          rv           = (cmd_q == CMD_WRITE) ? wv_q : hit_value;
          st           = ST_HIT;
        end else if (count_q != FULL_COUNT) begin
          do_append = 1'b1;
          rv        = (cmd_q == CMD_WRITE) ? wv_q : '0;
          st        = ST_INSERTED;
          count_d   = count_q + 1'b1;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_PEEK: begin
        if (hit) begin
          rv = hit_value;
          st = ST_HIT;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          do_remove = 1'b1;
          st        = ST_HIT;
          count_d   = count_q - 1'b1;
        end
      end
      CMD_CLEAR: begin
        st      = ST_HIT;
        count_d = '0;
      end
      default: ;
    endcase
  end

  assign ctrl.cmp_en    = (state_q == S_CMP);
  assign ctrl.write_hit = proceed && do_write_hit;
  assign ctrl.append    = proceed && do_append;
  assign ctrl.remove    = proceed && do_remove;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0]   nbr_key;
    logic [VALUE_BITS-1:0] nbr_value;
    if (g == ENTRIES - 1) begin : g_top
      assign nbr_key   = cell_key[g];
      assign nbr_value = cell_value[g];
    end else begin : g_mid
      assign nbr_key   = cell_key[g+1];
      assign nbr_value = cell_value[g+1];
    end
    lskv_cell #(
      .INDEX      (g),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .req_key_i   (key_q),
      .upd_value_i (rv),
      .count_i     (count_q),
      .hit_idx_i   (hit_idx),
      .nbr_key_i   (nbr_key),
      .nbr_value_i (nbr_value),
      .key_o       (cell_key[g]),
      .value_o     (cell_value[g]),
      .match_o     (cell_match[g])
    );
  end

  assign rv_ext    = {32'b0, rv};
  assign count_ext = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (proceed) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= command_i;
      key_q <= key_i;
      wv_q  <= write_value_i;
    end
    if (proceed) begin
      read_value_q  <= rv_ext[31:0];
      status_q      <= st;
      entry_count_q <= count_ext[4:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear-search key/value table.
// ----------------------------------------------------------------------------
// A driver presents requests from a pending queue with random gaps. The
// receiving side stalls at random. Every accepted request is run through a
// table model kept in the bench. The expected result is queued and compared
// field by field with each result transfer. A short directed sequence covers
// the following cases:
//   - a remove on an empty table,
//   - misses and hits,
//   - the unused command codes,
//   - a full table refusing an insert,
//   - clear.
// Random traffic on a small key pool then keeps the table busy near full.
// ----------------------------------------------------------------------------
module tb;
  import lskv_pkg::*;

  localparam int          TABLE_DEPTH   = 16;
  localparam int          KEY_POOL_SIZE = 24;
  localparam int          RANDOM_ITEMS  = 800;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] wval;
    bit          drain;  // hold this request until all results are back
  } table_request_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
    logic [4:0]  count;
  } table_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] write_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_value_o;
  logic [1:0]  status_o;
  logic [4:0]  entry_count_o;

  table_request_t request_q[$];
  table_result_t  expected_q[$];
  table_request_t next_req;
  table_result_t  predicted;
  table_result_t  oldest;

  // Table model kept by the bench.
  logic [31:0] model_keys[TABLE_DEPTH];
  logic [31:0] model_values[TABLE_DEPTH];
  int          model_held = 0;

  logic [31:0] key_pool[KEY_POOL_SIZE];
  bit          in_taken = 1'b0;
  int          sent_cnt = 0;
  int          recv_cnt = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          quiet_in;
  bit          quiet_out;

  linear_search_key_value_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the model and work out the result it gives.
  task automatic lookup_and_update(input logic [2:0] cmd, input logic [31:0] key,
                                   input logic [31:0] wval, output table_result_t res);
    int idx;
    bit hit;
    idx = model_held;
    for (int i = 0; i < model_held; i++) begin
      if (idx == model_held && model_keys[i] == key) idx = i;
    end
    hit = (idx < model_held);
    res.value  = '0;
    res.status = ST_MISS;
    case (cmd)
      CMD_READ_INSERT, CMD_WRITE: begin
        if (hit) begin
          if (cmd == CMD_WRITE) model_values[idx] = wval;
          res.value  = model_values[idx];
          res.status = ST_HIT;
        end else if (model_held < TABLE_DEPTH) begin
          res.value = (cmd == CMD_WRITE) ? wval : '0;
          model_keys[model_held]   = key;
          model_values[model_held] = res.value;
          model_held++;
          res.status = ST_INSERTED;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_PEEK: begin
        if (hit) begin
          res.value  = model_values[idx];
          res.status = ST_HIT;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          // Entries above the removed one move down to close the gap.
          for (int i = idx; i + 1 < model_held; i++) begin
            model_keys[i]   = model_keys[i + 1];
            model_values[i] = model_values[i + 1];
          end
          model_held--;
          res.status = ST_HIT;
        end
      end
      CMD_CLEAR: begin
        model_held = 0;
        res.status = ST_HIT;
      end
      default: ;
    endcase
    res.count = model_held[4:0];
  endtask

  task automatic queue_request(input logic [2:0] cmd, input logic [31:0] key,
                               input logic [31:0] wval, input bit drain);
    table_request_t r;
    r.cmd   = cmd;
    r.key   = key;
    r.wval  = wval;
    r.drain = drain;
    request_q.push_back(r);
  endtask

  assign quiet_in  = (sent_cnt >= 300) && (sent_cnt < 460);
  assign quiet_out = (recv_cnt >= 300) && (recv_cnt < 460);

  // Driver: a request that was not taken stays on the pins unchanged.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (request_q.size() == 0 ||
          (!quiet_in && $urandom_range(0, 99) < 28) ||
          (request_q[0].drain && expected_q.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        next_req = request_q.pop_front();
        command_i     <= next_req.cmd;
        key_i         <= next_req.key;
        write_value_i <= next_req.wval;
        in_valid_i    <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && !quiet_out && ($urandom_range(0, 99) < 28);
  end

  // Monitor. The result transfer is checked before this edge's request is
  // added, so an unexpected result can never match the new expectation.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      recv_cnt++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_cnt++;
      end else begin
        oldest = expected_q.pop_front();
        if (read_value_o !== oldest.value) begin
          $error("read_value mismatch: expected %h, actual %h", oldest.value, read_value_o);
          fail_cnt++;
        end
        if (status_o !== oldest.status) begin
          $error("status mismatch: expected %0d, actual %0d", oldest.status, status_o);
          fail_cnt++;
        end
        if (entry_count_o !== oldest.count) begin
          $error("entry_count mismatch: expected %0d, actual %0d", oldest.count,
                 entry_count_o);
          fail_cnt++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      lookup_and_update(command_i, key_i, write_value_i, predicted);
      expected_q.push_back(predicted);
      sent_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          counted;
    int          pick;
    logic [2:0]  cmd;
    logic [31:0] key;

    // Directed part.
    queue_request(CMD_REMOVE, 32'd5, 32'h0, 1'b0);             // remove on an empty table
    queue_request(CMD_PEEK, 32'h0, 32'hFFFF_FFFF, 1'b0);       // peek miss, no insert
    queue_request(CMD_READ_INSERT, 32'h0, 32'h1234_5678, 1'b0);
    queue_request(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(CMD_WRITE, 32'h0, 32'hFFFF_FFFF, 1'b0);      // write hit
    queue_request(CMD_PEEK, 32'hFFFF_FFFF, 32'h0, 1'b0);
    queue_request(CMD_READ_INSERT, 32'h0, 32'h0, 1'b0);        // read hit
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      queue_request(c[2:0], 32'h0, 32'hFFFF_FFFF, 1'b0);
    end
    queue_request(CMD_REMOVE, 32'h0, 32'h0, 1'b0);
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      queue_request(CMD_WRITE, 32'(i), ~32'(i), 1'b0);
    end
    queue_request(CMD_READ_INSERT, 32'hA5A5_A5A5, 32'h0, 1'b0); // full, refused
    queue_request(CMD_WRITE, 32'h5A5A_5A5A, 32'h1, 1'b0);       // full, refused
    queue_request(CMD_REMOVE, 32'd3, 32'h0, 1'b0);              // remove from the middle
    queue_request(CMD_CLEAR, 32'h0, 32'h0, 1'b0);

    // A small key pool keeps hits frequent and the table near full.
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      cmd = CMD_READ_INSERT;
      else if (pick < 65) cmd = CMD_WRITE;
      else if (pick < 80) cmd = CMD_PEEK;
      else if (pick < 95) cmd = CMD_REMOVE;
      else if (pick < 97) cmd = CMD_CLEAR;
      else                cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      // Every couple of hundred requests the sender waits for the table to drain.
      queue_request(cmd, key, $urandom, (counted % 200) == 199);
      if (cmd <= CMD_CLEAR) counted++;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid_i || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
